/* hw/rtl/bwc_pkg.sv */
// shared types, constants and a helper function for the barcode whitelist corrector
package bwc_pkg;

    localparam int BWC_TABLE_DEPTH = 1024;

    localparam int SYM_W       = 3;
    localparam int NUM_SYM     = 21;
    localparam int CODE_W      = SYM_W * NUM_SYM;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 5;
    localparam int KEY_W       = POS_W + 2;
    localparam int IDX_W       = 10;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXACT     = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_NONE      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PASS1,
        S_DRAIN1,
        S_DECIDE,
        S_PASS2,
        S_DRAIN2,
        S_FINISH
    } t_state;

    // step k (1..4) with c == (b + k) mod 5, or 0 when c is no such neighbor of b
    function automatic logic [2:0] cousin_step(input logic [2:0] b, input logic [2:0] c);
        logic [2:0] bm;
        logic [3:0] t;
        bm = (b >= 3'd5) ? (b - 3'd5) : b;
        t  = 4'(c) + 4'd5 - 4'(bm);
        if (t >= 4'd5) begin
            t = t - 4'd5;
        end
        if ((c > 3'd4) || (c == bm)) begin
            return 3'd0;
        end
        return 3'(t);
    endfunction

endpackage

/* hw/rtl/barcode_whitelist_correct.sv */
// cell barcode whitelist with exact match and one-symbol correction
//
// input stream (s side): tuser selects load or query; a load writes one table
// entry (codeword, correctable flag) in the cycle it is accepted and gives no
// result; a query scans the entry memory and gives one result transaction
// output stream (m side): tuser carries the match status, tdata the entry index
// config: i_cfg_we writes the barcode length (symbols per barcode) at once
// reset: valid flags live in the entry memory, so a clearing pass walks all
// TABLE_DEPTH entries, one a cycle; tready stays low during the clearing pass
// scans: a query that matches exactly or not at all takes one scan of the
// table; a corrected query takes a second scan, which finds the highest index
// holding the winning codeword
// the single read port of the entry memory means that one entry is compared
// per cycle by one shared compare unit under the sequencer
// one item is in work at a time; a finished result sits in the output register
// while a new item is accepted; if the receiver stalls, the next query waits
// with its result until the output register is free
module barcode_whitelist_correct
    import bwc_pkg::*;
#(
    parameter int TABLE_DEPTH = BWC_TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [LEN_W-1:0]       i_cfg_wdata,
    // request stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // entry_index[9:0], codeword[72:10], correctable[73], barcode[136:74], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // req_type[0]
    input  logic                   i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // cell_index[9:0], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // match_status[1:0]
    output logic [STATUS_W-1:0]    o_m_tuser
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MEM_W = CODE_W + 2;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    // entry memory: {valid, correctable, codeword}
    logic [MEM_W-1:0] r_mem [TABLE_DEPTH];
    logic [MEM_W-1:0] r_rd_data;

    // sequencer
    t_state r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;

    // read pipeline tag
    logic          r_pv;
    logic          r_ppass;
    logic [AW-1:0] r_pidx;

    // query and scan results
    logic [CODE_W-1:0] r_query;
    logic [LEN_W-1:0]  r_barcode_length;
    logic              r_exact_found, n_exact_found;
    logic [AW-1:0]     r_exact_idx, n_exact_idx;
    logic              r_corr_found, n_corr_found;
    logic [KEY_W-1:0]  r_best_key, n_best_key;
    logic [CODE_W-1:0] r_best_code, n_best_code;
    logic [AW-1:0]     r_hit2_idx, n_hit2_idx;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [IDX_W-1:0]    r_out_index;

    // input fields
    logic              w_in_req;
    logic [IDX_W-1:0]  w_in_index;
    logic [CODE_W-1:0] w_in_code;
    logic              w_in_corr;
    logic [CODE_W-1:0] w_in_barcode;
    logic              w_accept;
    logic              w_load_ok;

    // control outputs of the sequencer
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [MEM_W-1:0]  w_mem_wdata;
    logic              w_issue;
    logic              w_out_free;
    logic              w_post;
    t_status           w_post_status;
    logic [IDX_W-1:0]  w_post_index;

    // compare unit
    logic [CODE_W-1:0]  w_ent_code;
    logic               w_ent_corr;
    logic               w_ent_valid;
    logic [NUM_SYM-1:0] w_diff;
    logic [POS_W-1:0]   w_pos;
    logic [SYM_W-1:0]   w_sym_b;
    logic [SYM_W-1:0]   w_sym_c;
    logic [2:0]         w_step;
    logic [KEY_W-1:0]   w_key;
    logic               w_exact_hit;
    logic               w_cousin_hit;
    logic               w_pass2_hit;

    assign w_in_req     = i_s_tuser;
    assign w_in_index   = i_s_tdata[9:0];
    assign w_in_code    = i_s_tdata[72:10];
    assign w_in_corr    = i_s_tdata[73];
    assign w_in_barcode = i_s_tdata[136:74];

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_load_ok = (32'(w_in_index) < 32'(TABLE_DEPTH));
    assign w_out_free = !r_out_valid || i_m_tready;

    // ---------------------------------------------------------------
    // entry memory: one write port, one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // ---------------------------------------------------------------
    // shared compare unit, one entry per cycle
    // ---------------------------------------------------------------
    assign w_ent_code  = r_rd_data[CODE_W-1:0];
    assign w_ent_corr  = r_rd_data[CODE_W];
    assign w_ent_valid = r_rd_data[CODE_W+1];

    always_comb begin
        w_pos   = '0;
        w_sym_b = '0;
        w_sym_c = '0;
        for (int s = 0; s < NUM_SYM; s++) begin
            w_diff[s] = (w_ent_code[s*SYM_W +: SYM_W] != r_query[s*SYM_W +: SYM_W]);
        end
        // at most one bit is set when it matters, so or-ing works as the encoder
        for (int s = 0; s < NUM_SYM; s++) begin
            if (w_diff[s]) begin
                w_pos   = w_pos | POS_W'(s);
                w_sym_b = w_sym_b | r_query[s*SYM_W +: SYM_W];
                w_sym_c = w_sym_c | w_ent_code[s*SYM_W +: SYM_W];
            end
        end
    end

    assign w_step = cousin_step(w_sym_b, w_sym_c);
    assign w_key  = {w_pos, 2'(w_step - 3'd1)};

    assign w_exact_hit  = r_pv && !r_ppass && w_ent_valid && (w_ent_code == r_query);
    assign w_cousin_hit = r_pv && !r_ppass && w_ent_valid && w_ent_corr && $onehot(w_diff)
                          && (w_pos < r_barcode_length) && (w_step != 3'd0);
    assign w_pass2_hit  = r_pv && r_ppass && w_ent_valid && (w_ent_code == r_best_code);

    // scan result updates; ascending scan, so the last equal entry is the highest
    always_comb begin
        n_exact_found = r_exact_found;
        n_exact_idx   = r_exact_idx;
        n_corr_found  = r_corr_found;
        n_best_key    = r_best_key;
        n_best_code   = r_best_code;
        n_hit2_idx    = r_hit2_idx;
        if (w_accept && (w_in_req == REQ_QUERY)) begin
            n_exact_found = 1'b0;
            n_corr_found  = 1'b0;
        end
        if (w_exact_hit) begin
            n_exact_found = 1'b1;
            n_exact_idx   = r_pidx;
        end
        if (w_cousin_hit && (!r_corr_found || (w_key < r_best_key))) begin
            n_corr_found = 1'b1;
            n_best_key   = w_key;
            n_best_code  = w_ent_code;
        end
        if (w_pass2_hit) begin
            n_hit2_idx = r_pidx;
        end
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && (w_in_req == REQ_QUERY)) begin
                    n_state = S_PASS1;
                end
            end
            S_PASS1: begin
                if (r_addr == LAST) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_exact_found || !r_corr_found) begin
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_PASS2;
                end
            end
            S_PASS2: begin
                if (r_addr == LAST) begin
                    n_state = S_DRAIN2;
                end
            end
            S_DRAIN2: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        o_s_tready    = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_waddr   = r_addr;
        w_mem_wdata   = '0;
        w_issue       = 1'b0;
        w_post        = 1'b0;
        w_post_status = ST_NONE;
        w_post_index  = '0;
        case (r_state)
            S_CLEAR: begin
                // write invalid entries, one a cycle
                w_mem_we = 1'b1;
            end
            S_IDLE: begin
                o_s_tready  = 1'b1;
                w_mem_we    = w_accept && (w_in_req == REQ_LOAD) && w_load_ok;
                w_mem_waddr = AW'(w_in_index);
                w_mem_wdata = {1'b1, w_in_corr, w_in_code};
            end
            S_PASS1, S_PASS2: begin
                w_issue = 1'b1;
            end
            S_DECIDE: begin
                if (r_exact_found) begin
                    w_post        = w_out_free;
                    w_post_status = ST_EXACT;
                    w_post_index  = IDX_W'(r_exact_idx);
                end else if (!r_corr_found) begin
                    w_post        = w_out_free;
                    w_post_status = ST_NONE;
                end
            end
            S_FINISH: begin
                w_post        = w_out_free;
                w_post_status = ST_CORRECTED;
                w_post_index  = IDX_W'(r_hit2_idx);
            end
            default: begin
                w_issue = 1'b0;
            end
        endcase
    end

    // address walks the memory during clearing and both scans, wrapping to zero
    always_comb begin
        n_addr = r_addr;
        if ((r_state == S_CLEAR) || w_issue) begin
            n_addr = (r_addr == LAST) ? '0 : (r_addr + AW'(1));
        end else if (r_state == S_IDLE) begin
            n_addr = '0;
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_addr           <= '0;
            r_pv             <= 1'b0;
            r_barcode_length <= LEN_RESET;
            r_exact_found    <= 1'b0;
            r_corr_found     <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_addr        <= n_addr;
            r_pv          <= w_issue;
            r_exact_found <= n_exact_found;
            r_corr_found  <= n_corr_found;
            if (i_cfg_we) begin
                r_barcode_length <= i_cfg_wdata;
            end
            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ppass     <= (r_state == S_PASS2);
        r_pidx      <= r_addr;
        r_exact_idx <= n_exact_idx;
        r_best_key  <= n_best_key;
        r_best_code <= n_best_code;
        r_hit2_idx  <= n_hit2_idx;
        if (w_accept && (w_in_req == REQ_QUERY)) begin
            r_query <= w_in_barcode;
        end
        if (w_post) begin
            r_out_status <= w_post_status;
            r_out_index  <= w_post_index;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_index);

`ifndef NO_ASSERTIONS
    // no request is taken while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("request accepted during clearing pass");

    // an unmatched result always reports index zero
    a_none_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_NONE)) |-> (o_m_tdata == '0))
        else $error("unmatched result with nonzero index");

    // the second scan only runs when a correctable cousin was found
    a_pass2_has_cousin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS2) |-> (r_corr_found && !r_exact_found))
        else $error("second scan without a cousin");

    // read data is only evaluated right after a scan cycle issued the read
    a_pipe_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (($past(r_state) == S_PASS1) || ($past(r_state) == S_PASS2)))
        else $error("read pipeline valid outside a scan");
`endif

endmodule

/* verif/tb.sv */
// self-checking testbench for the barcode whitelist corrector
`timescale 1ns / 1ps

module tb;
    import bwc_pkg::*;

    localparam int DEPTH = BWC_TABLE_DEPTH;
    localparam logic [CODE_W-1:0] ALL_ONES = {CODE_W{1'b1}};

    // expected query outcome, one per accepted query transaction
    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
    } t_match;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    // entry_index[9:0], codeword[72:10], correctable[73], barcode[136:74], zero pad
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    // req_type[0]
    logic                   i_s_tuser   = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    // cell_index[9:0], zero pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // match_status[1:0]
    logic [STATUS_W-1:0]    o_m_tuser;

    barcode_whitelist_correct uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the whitelist and the length register
    logic [CODE_W-1:0] code_store [DEPTH];
    bit                slot_valid [DEPTH];
    bit                slot_fixable [DEPTH];
    int                sym_count = int'(LEN_RESET);
    int                loaded_slots [$];

    t_match expected_matches [$];

    // idle knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    int err_count      = 0;
    int loads_sent     = 0;
    int queries_sent   = 0;
    int seen_exact     = 0;
    int seen_corrected = 0;
    int seen_unmatched = 0;

    function automatic logic [CODE_W-1:0] rand_code();
        return CODE_W'({$urandom, $urandom});
    endfunction

    function automatic logic [CODE_W-1:0] with_sym(logic [CODE_W-1:0] code, int pos,
                                                   logic [SYM_W-1:0] val);
        logic [CODE_W-1:0] r;
        r = code;
        r[SYM_W*pos +: SYM_W] = val;
        return r;
    endfunction

    // exact hit first (highest index), then cousins by position then step
    function automatic t_match lookup_barcode(logic [CODE_W-1:0] bc);
        int                top_of [logic [CODE_W-1:0]];
        bit                fixable [logic [CODE_W-1:0]];
        t_match            r;
        int                eff;
        logic [SYM_W-1:0]  b;
        logic [CODE_W-1:0] cz;
        for (int j = 0; j < DEPTH; j++) begin
            if (slot_valid[j]) begin
                top_of[code_store[j]] = j;
                if (slot_fixable[j]) begin
                    fixable[code_store[j]] = 1'b1;
                end
            end
        end
        r.status = ST_NONE;
        r.index  = '0;
        if (top_of.exists(bc)) begin
            r.status = ST_EXACT;
            r.index  = IDX_W'(top_of[bc]);
            return r;
        end
        eff = (sym_count > NUM_SYM) ? NUM_SYM : sym_count;
        for (int i = 0; i < eff; i++) begin
            b = bc[SYM_W*i +: SYM_W];
            for (int k = 1; k <= 4; k++) begin
                cz = with_sym(bc, i, SYM_W'((int'(b) + k) % 5));
                if (fixable.exists(cz)) begin
                    // reported slot need not be the correctable one
                    r.status = ST_CORRECTED;
                    r.index  = IDX_W'(top_of[cz]);
                    return r;
                end
            end
        end
        return r;
    endfunction

    // drive one request and wait for its transaction; tvalid stays up on return
    task automatic send_request(t_req req, logic [IDX_W-1:0] slot, logic [CODE_W-1:0] code,
                                bit fix, logic [CODE_W-1:0] bc);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {7'd0, bc, fix, code, slot};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        if (req == REQ_LOAD) begin
            code_store[slot]   = code;
            slot_valid[slot]   = 1'b1;
            slot_fixable[slot] = fix;
            loaded_slots       = {loaded_slots, int'(slot)};
            loads_sent++;
        end else begin
            expected_matches = {expected_matches, lookup_barcode(bc)};
            queries_sent++;
        end
    endtask

    task automatic load_entry(int slot, logic [CODE_W-1:0] code, bit fix);
        send_request(REQ_LOAD, IDX_W'(slot), code, fix, rand_code());
    endtask

    task automatic query(logic [CODE_W-1:0] bc);
        send_request(REQ_QUERY, IDX_W'($urandom), rand_code(), 1'($urandom), bc);
    endtask

    // sender holds off until every pending query has returned, then a short settle
    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        while (expected_matches.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_length(int n);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LEN_W'(n);
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        sym_count = n;
    endtask

    // extremes of slot index and codeword, a non-correctable entry, symbol 7
    task automatic test_extremes();
        load_entry(0, ALL_ONES, 1'b1);
        load_entry(DEPTH - 1, '0, 1'b0);
        query(ALL_ONES);
        query('0);
        // cousin of an entry that is not correctable
        query(with_sym('0, 0, 3'd4));
        // symbol 7 can never be reached by a step
        query(with_sym(ALL_ONES, 15, 3'd6));
    endtask

    // duplicates, reload and position/step priority
    task automatic test_duplicates(logic [CODE_W-1:0] x1);
        logic [CODE_W-1:0] q;
        logic [SYM_W-1:0]  b0;
        q  = with_sym(x1, 2, 3'd0);
        b0 = q[SYM_W-1:0];
        load_entry(5, x1, 1'b1);
        load_entry(700, x1, 1'b0);
        query(x1);
        // corrected, reported slot is the non-correctable duplicate
        query(q);
        query(with_sym(x1, 2, 3'd7));
        load_entry(700, ~x1, 1'b1);
        query(x1);
        // lower position wins over the hit at position 2, lower step over higher
        load_entry(7, with_sym(q, 0, SYM_W'((int'(b0) + 3) % 5)), 1'b1);
        load_entry(6, with_sym(q, 0, SYM_W'((int'(b0) + 1) % 5)), 1'b1);
        query(q);
    endtask

    // zero, overlong and single-symbol lengths; high bits compared unchanged
    task automatic test_lengths(logic [CODE_W-1:0] x1);
        write_length(0);
        query(with_sym(x1, 2, 3'd0));
        query(x1);
        write_length(31);
        query(with_sym(x1, NUM_SYM - 1, 3'd1));
        write_length(1);
        query(with_sym(x1, NUM_SYM - 1, 3'd1));
        query(with_sym(x1, 0, 3'd2));
    endtask

    // loads plus queries mostly derived from stored codewords, some noise
    task automatic test_random_traffic(int n, int len, int idle, int stall);
        int                pick;
        int                eff;
        logic [CODE_W-1:0] base;
        write_length(len);
        idle_pct  = idle;
        stall_pct = stall;
        for (int t = 0; t < n; t++) begin
            eff  = (len > NUM_SYM) ? NUM_SYM : len;
            base = (loaded_slots.size() != 0) ?
                   code_store[loaded_slots[$urandom_range(loaded_slots.size() - 1)]] :
                   rand_code();
            pick = $urandom_range(99);
            if (pick < 40) begin
                // a quarter of loads copy an existing codeword
                load_entry($urandom_range(DEPTH - 1),
                           ($urandom_range(3) == 0) ? base : rand_code(), 1'($urandom));
            end else if (pick < 58) begin
                query(base);
            end else if (pick < 84) begin
                query(with_sym(base, (eff > 0) ? $urandom_range(eff - 1) : $urandom_range(20),
                               SYM_W'($urandom)));
            end else if (pick < 91) begin
                query(with_sym(with_sym(base, $urandom_range(NUM_SYM - 1), SYM_W'($urandom)),
                               $urandom_range(NUM_SYM - 1), SYM_W'($urandom)));
            end else begin
                query(rand_code());
            end
        end
        wait_results_drained();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // result side: random stall and in-order compare
    always @(posedge i_clk) begin : result_check
        t_match want;
        i_m_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_matches.size() == 0) begin
                $error("unexpected result transaction: match_status %0d cell_index %0d",
                       o_m_tuser, o_m_tdata[IDX_W-1:0]);
                err_count++;
            end else begin
                want = expected_matches.pop_front();
                if (o_m_tuser !== want.status) begin
                    $error("match_status: expected %0d, got %0d", want.status, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[IDX_W-1:0] !== want.index) begin
                    $error("cell_index: expected %0d, got %0d", want.index,
                           o_m_tdata[IDX_W-1:0]);
                    err_count++;
                end
                case (want.status)
                    ST_EXACT:     seen_exact++;
                    ST_CORRECTED: seen_corrected++;
                    default:      seen_unmatched++;
                endcase
            end
        end
    end

    // sequence of tests
    initial begin : main_seq
        logic [CODE_W-1:0] x1;
        // symbol 0 is 3 and symbol 20 is 2, so both ends are reachable by a step
        x1 = with_sym(63'h2345_6789_ABCD_EF03, 2, 3'd1);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_duplicates(x1);
        test_lengths(x1);
        test_random_traffic(120, 21, 0, 0);
        test_random_traffic(110, 12, 78, 0);
        test_random_traffic(110, 22, 0, 78);
        test_random_traffic(110, 3, 9, 9);
        wait_results_drained();
        $display("ran %0d loads and %0d queries, lengths 0 to 31, four idle and stall mixes",
                 loads_sent, queries_sent);
        $display("checked %0d exact, %0d corrected and %0d unmatched results",
                 seen_exact, seen_corrected, seen_unmatched);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
